// File: rtl/oriented_box_grid_rasterizer_top_macros.svh
// assertion macros used by the rasterizer top level
`ifndef ORIENTED_BOX_GRID_RASTERIZER_TOP_MACROS_SVH
`define ORIENTED_BOX_GRID_RASTERIZER_TOP_MACROS_SVH

// property that must hold at every clock edge out of reset
`define OBR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define OBR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/obrast_pkg.sv
// types, constants and register codes of the oriented box rasterizer
package obrast_pkg;

  localparam int GRID_WIDTH_DEF  = 1024;
  localparam int GRID_HEIGHT_DEF = 1024;

  // half diagonal of the car footprint, rounded up, Q16.16 metres
  localparam logic signed [33:0] DIAG_Q16 = 34'sd10264;
  // footprint half length and half width, Q.47
  localparam logic signed [60:0] HALF_LEN_Q47 = 61'sd21110623253299;
  localparam logic signed [60:0] HALF_WID_Q47 = 61'sd6333186975989;
  // offset clamp before the rotation, Q.17
  localparam logic signed [35:0] OFFSET_SAT = 36'sd33554432;
  localparam logic [6:0] MAX_HITS = 7'd64;

  // configuration register indexes
  localparam logic [2:0] CFG_ORIGIN_X   = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y   = 3'd1;
  localparam logic [2:0] CFG_CELL_SIZE  = 3'd2;
  localparam logic [2:0] CFG_CELLS_PM   = 3'd3;
  localparam logic [2:0] CFG_WIN_MIN_X  = 3'd4;
  localparam logic [2:0] CFG_WIN_MIN_Y  = 3'd5;
  localparam logic [2:0] CFG_WIN_MAX_X  = 3'd6;
  localparam logic [2:0] CFG_WIN_MAX_Y  = 3'd7;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } in_item_t;

  typedef struct packed {
    logic [9:0] cell_x;
    logic [9:0] cell_y;
    logic       last_cell;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic [16:0]        cell_size;
    logic [20:0]        cells_per_metre;
    logic [10:0]        win_min_x;
    logic [10:0]        win_min_y;
    logic [10:0]        win_max_x;
    logic [10:0]        win_max_y;
  } cfg_t;

  // classified work handed from front to back
  typedef struct packed {
    logic               obstacle;
    logic               hit_any;
    logic [10:0]        x0;
    logic [10:0]        x1;
    logic [10:0]        y0;
    logic [10:0]        y1;
    logic signed [35:0] dx0;
    logic signed [35:0] dy0;
    logic [17:0]        step;
    logic signed [32:0] cq;
    logic signed [32:0] sq;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/obrast_queue.sv
// two-entry job queue between front and back
module obrast_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  obrast_pkg::job_t  din,
  input  logic              pop,
  output obrast_pkg::job_t  dout,
  output obrast_pkg::q_stat_t stat
);
  import obrast_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign dout       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

// File: rtl/obrast_front.sv
// front end: takes a request, works out the box bounds and heading, queues a job
module obrast_front #(
  parameter int GRID_WIDTH  = obrast_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = obrast_pkg::GRID_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  obrast_pkg::in_item_t in_data,
  input  obrast_pkg::cfg_t     cfg,
  input  obrast_pkg::q_stat_t  qstat,
  output logic                 push,
  output obrast_pkg::job_t     job
);
  import obrast_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_CLIP, F_PUSH} f_state_t;

  f_state_t           state_r;
  in_item_t           item_r;
  logic [1:0]         cnt_r;
  logic signed [23:0] bnd_r [4];
  logic [1:0]         neg_r;
  job_t               job_r;

  logic signed [31:0] p_sel, o_sel;
  logic signed [33:0] diag, oper;
  logic signed [21:0] cpm_s;
  logic signed [55:0] prod, rnd;
  logic signed [23:0] bound;
  logic signed [23:0] wminx, wminy, wmaxx, wmaxy, gwm1, ghm1;
  logic signed [23:0] lo_x, hi_x, lo_y, hi_y;
  logic               empty, obst_ok;
  logic [28:0]        mx, my;
  logic signed [31:0] ww, zz, zw;
  job_t               job_nxt;

  // shared bound multiplier: x floor, x ceil, y floor, y ceil
  always_comb begin
    p_sel = cnt_r[1] ? item_r.pos_y : item_r.pos_x;
    o_sel = cnt_r[1] ? cfg.origin_y : cfg.origin_x;
    diag  = item_r.operation ? 34'sd0 : DIAG_Q16;
    oper  = 34'(p_sel) - 34'(o_sel) + (cnt_r[0] ? diag : -diag);
    cpm_s = $signed({1'b0, cfg.cells_per_metre});
    prod  = oper * cpm_s;
    rnd   = cnt_r[0] ? prod + 56'sd4294967295 : prod;
    bound = rnd[55:32];
  end

  // clip to window and grid, offsets of the first cell, heading
  always_comb begin
    wminx = $signed({13'b0, cfg.win_min_x});
    wminy = $signed({13'b0, cfg.win_min_y});
    wmaxx = $signed({13'b0, cfg.win_max_x}) - 24'sd1;
    wmaxy = $signed({13'b0, cfg.win_max_y}) - 24'sd1;
    gwm1  = 24'(GRID_WIDTH - 1);
    ghm1  = 24'(GRID_HEIGHT - 1);

    lo_x = (bnd_r[0] > wminx) ? bnd_r[0] : wminx;
    if (lo_x < 24'sd0) lo_x = 24'sd0;
    hi_x = (bnd_r[1] < wmaxx) ? bnd_r[1] : wmaxx;
    if (hi_x > gwm1) hi_x = gwm1;
    lo_y = (bnd_r[2] > wminy) ? bnd_r[2] : wminy;
    if (lo_y < 24'sd0) lo_y = 24'sd0;
    hi_y = (bnd_r[3] < wmaxy) ? bnd_r[3] : wmaxy;
    if (hi_y > ghm1) hi_y = ghm1;
    empty = (lo_x > hi_x) || (lo_y > hi_y);

    obst_ok = !neg_r[0] && !neg_r[1] && (bnd_r[0] <= gwm1) && (bnd_r[2] <= ghm1);

    mx = {lo_x[10:0], 1'b1} * cfg.cell_size;
    my = {lo_y[10:0], 1'b1} * cfg.cell_size;
    ww = item_r.quat_w * item_r.quat_w;
    zz = item_r.quat_z * item_r.quat_z;
    zw = item_r.quat_z * item_r.quat_w;

    job_nxt.obstacle = item_r.operation;
    job_nxt.hit_any  = item_r.operation ? obst_ok : !empty;
    job_nxt.x0       = item_r.operation ? bnd_r[0][10:0] : lo_x[10:0];
    job_nxt.y0       = item_r.operation ? bnd_r[2][10:0] : lo_y[10:0];
    job_nxt.x1       = hi_x[10:0];
    job_nxt.y1       = hi_y[10:0];
    job_nxt.dx0      = 36'($signed({cfg.origin_x, 1'b0})) + $signed({7'b0, mx})
                       - 36'($signed({item_r.pos_x, 1'b0}));
    job_nxt.dy0      = 36'($signed({cfg.origin_y, 1'b0})) + $signed({7'b0, my})
                       - 36'($signed({item_r.pos_y, 1'b0}));
    job_nxt.step     = {cfg.cell_size, 1'b0};
    job_nxt.cq       = 33'(ww) - 33'(zz);
    job_nxt.sq       = $signed({zw, 1'b0});
  end

  assign in_stall = (state_r != F_IDLE);
  assign push     = (state_r == F_PUSH) && !qstat.full;
  assign job      = job_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= 2'd0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            cnt_r   <= 2'd0;
            state_r <= F_MUL;
          end
        end
        F_MUL: begin
          bnd_r[cnt_r] <= bound;
          if (cnt_r == 2'd0) neg_r[0] <= (oper < 34'sd0);
          if (cnt_r == 2'd2) neg_r[1] <= (oper < 34'sd0);
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd3) state_r <= F_CLIP;
        end
        F_CLIP: begin
          job_r   <= job_nxt;
          state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!qstat.full) state_r <= F_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/obrast_back.sv
// back end: scans the box one cell a cycle unless the output stalls, tests it and emits hits
module obrast_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  obrast_pkg::job_t      job,
  input  obrast_pkg::q_stat_t   qstat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output obrast_pkg::out_item_t out_data
);
  import obrast_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_SCAN, B_WAIT, B_FLUSH} b_state_t;

  b_state_t           state_r;
  job_t               cur_r;
  logic [10:0]        gx_r, gy_r;
  logic signed [35:0] dx_r, dy_r;

  logic               s1_v_r, s1_last_r;
  logic [10:0]        s1_gx_r, s1_gy_r;
  logic signed [26:0] s1_dx_r, s1_dy_r;

  logic               s2_v_r, s2_last_r;
  logic [10:0]        s2_gx_r, s2_gy_r;
  logic signed [59:0] pxc_r, pys_r, pyc_r, pxs_r;

  logic               pend_v_r;
  logic [9:0]         pend_x_r, pend_y_r;
  logic [6:0]         n_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               adv, scan_last, hit, take, emit;
  logic signed [60:0] lx, ly;

  function automatic logic signed [26:0] sat_off(input logic signed [35:0] v);
    logic signed [26:0] r;
    if (v > OFFSET_SAT)       r = 27'sd33554432;
    else if (v < -OFFSET_SAT) r = -27'sd33554432;
    else                      r = v[26:0];
    return r;
  endfunction

  // whole pipeline moves only when the output slot can take a cell
  assign adv       = !out_valid_r || !out_stall;
  assign scan_last = (gx_r == cur_r.x1) && (gy_r == cur_r.y1);
  assign pop       = adv && (state_r == B_IDLE) && !qstat.empty;

  // rotated offset test and whether the output slot is loaded this cycle
  always_comb begin
    lx   = 61'(pxc_r) + 61'(pys_r);
    ly   = 61'(pyc_r) - 61'(pxs_r);
    hit  = (lx <= HALF_LEN_Q47) && (lx >= -HALF_LEN_Q47)
        && (ly <= HALF_WID_Q47) && (ly >= -HALF_WID_Q47);
    take = s2_v_r && hit && (n_r < MAX_HITS);
    emit = adv && ((take && pend_v_r)
        || ((state_r == B_IDLE) && !qstat.empty && job.obstacle && job.hit_any)
        || ((state_r == B_FLUSH) && pend_v_r));
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // scan sequencer, test pipeline and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      n_r         <= 7'd0;
    end else begin
      if (out_valid_r && !out_stall && !emit) out_valid_r <= 1'b0;
      if (adv) begin
        // products stage
        s2_v_r    <= s1_v_r;
        s2_last_r <= s1_last_r;
        s2_gx_r   <= s1_gx_r;
        s2_gy_r   <= s1_gy_r;
        pxc_r     <= s1_dx_r * cur_r.cq;
        pys_r     <= s1_dy_r * cur_r.sq;
        pyc_r     <= s1_dy_r * cur_r.cq;
        pxs_r     <= s1_dx_r * cur_r.sq;
        // clamp stage
        s1_v_r    <= (state_r == B_SCAN);
        s1_last_r <= scan_last;
        s1_gx_r   <= gx_r;
        s1_gy_r   <= gy_r;
        s1_dx_r   <= sat_off(dx_r);
        s1_dy_r   <= sat_off(dy_r);
        // hold the newest hit back until the next one shows it is not last
        if (take) begin
          if (pend_v_r) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '{cell_x: pend_x_r, cell_y: pend_y_r, last_cell: 1'b0};
          end
          pend_v_r <= 1'b1;
          pend_x_r <= s2_gx_r[9:0];
          pend_y_r <= s2_gy_r[9:0];
          n_r      <= n_r + 7'd1;
        end
        unique case (state_r)
          B_IDLE: begin
            if (!qstat.empty) begin
              if (job.obstacle) begin
                if (job.hit_any) begin
                  out_valid_r <= 1'b1;
                  out_data_r  <= '{cell_x: job.x0[9:0], cell_y: job.y0[9:0],
                                   last_cell: 1'b1};
                end
              end else if (job.hit_any) begin
                cur_r   <= job;
                gx_r    <= job.x0;
                gy_r    <= job.y0;
                dx_r    <= job.dx0;
                dy_r    <= job.dy0;
                n_r     <= 7'd0;
                state_r <= B_SCAN;
              end
            end
          end
          B_SCAN: begin
            if (scan_last) begin
              state_r <= B_WAIT;
            end else if (gy_r == cur_r.y1) begin
              gy_r <= cur_r.y0;
              dy_r <= cur_r.dy0;
              gx_r <= gx_r + 11'd1;
              dx_r <= dx_r + $signed({18'b0, cur_r.step});
            end else begin
              gy_r <= gy_r + 11'd1;
              dy_r <= dy_r + $signed({18'b0, cur_r.step});
            end
          end
          B_WAIT: begin
            if (s2_v_r && s2_last_r) state_r <= B_FLUSH;
          end
          B_FLUSH: begin
            if (pend_v_r) begin
              out_valid_r <= 1'b1;
              out_data_r  <= '{cell_x: pend_x_r, cell_y: pend_y_r, last_cell: 1'b1};
              pend_v_r    <= 1'b0;
            end
            state_r <= B_IDLE;
          end
        endcase
      end
    end
  end

endmodule

// File: rtl/oriented_box_grid_rasterizer_top.sv
// top level of the oriented box rasterizer: config registers, front, queue, back
//
// Usage: each request on the in_ channel is a car pose (operation 0) or an
// obstacle point (operation 1). The out_ channel returns the grid cells to
// mark lethal, last_cell set on the final cell of a request; a request that
// covers no cell returns nothing. Both channels use valid/stall handshakes.
// The cfg_ port writes the eight registers by index; it is always ready. It is to
// be written by the user only while the block is idle; the block has no check for it.
// Flow: the front runs each request through its shared bound multiplier (x floor,
// x ceil, y floor, y ceil), then a clip step and a queue push, and takes the next
// request only once that job is pushed. The back scans one cell per cycle, unless
// the output stalls, through a clamp stage and a products stage to the box test;
// a car scans every cell of its clipped box, an obstacle is emitted without a scan.
// A two-deep job queue lets the front work on the next request meanwhile.
// Reset (synchronous, rst_n low) loads the register defaults and empties the
// queue and pipeline. When out_stall holds back a valid cell the whole back pipeline freezes;
// the front keeps working until the queue is full, then stalls its input.
`include "oriented_box_grid_rasterizer_top_macros.svh"

module oriented_box_grid_rasterizer_top #(
  parameter int GRID_WIDTH  = obrast_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = obrast_pkg::GRID_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  obrast_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output obrast_pkg::out_item_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data
);
  import obrast_pkg::*;

  cfg_t    cfg_r;
  job_t    q_din, q_dout;
  q_stat_t q_stat;
  logic    q_push, q_pop;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x        <= 32'sd0;
      cfg_r.origin_y        <= 32'sd0;
      cfg_r.cell_size       <= 17'd3277;
      cfg_r.cells_per_metre <= 21'd1310720;
      cfg_r.win_min_x       <= 11'd0;
      cfg_r.win_min_y       <= 11'd0;
      cfg_r.win_max_x       <= 11'd1024;
      cfg_r.win_max_y       <= 11'd1024;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ORIGIN_X:  cfg_r.origin_x        <= $signed(cfg_data);
        CFG_ORIGIN_Y:  cfg_r.origin_y        <= $signed(cfg_data);
        CFG_CELL_SIZE: cfg_r.cell_size       <= cfg_data[16:0];
        CFG_CELLS_PM:  cfg_r.cells_per_metre <= cfg_data[20:0];
        CFG_WIN_MIN_X: cfg_r.win_min_x       <= cfg_data[10:0];
        CFG_WIN_MIN_Y: cfg_r.win_min_y       <= cfg_data[10:0];
        CFG_WIN_MAX_X: cfg_r.win_max_x       <= cfg_data[10:0];
        CFG_WIN_MAX_Y: cfg_r.win_max_y       <= cfg_data[10:0];
      endcase
    end
  end

  obrast_front #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .qstat    (q_stat),
    .push     (q_push),
    .job      (q_din)
  );

  obrast_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .stat  (q_stat)
  );

  obrast_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (q_dout),
    .qstat     (q_stat),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // queue never overrun or underrun, front busy right after taking a request
  `OBR_ASSERT(a_no_overrun, !(q_push && q_stat.full), "job pushed into full queue")
  `OBR_ASSERT(a_no_underrun, !(q_pop && q_stat.empty), "job popped from empty queue")
  `OBR_ASSERT_NEXT(a_front_busy, in_valid && !in_stall, in_stall, "front idle after accept")

endmodule

// File: dv/oriented_box_grid_rasterizer_top_test.sv
// self-checking testbench for the oriented box grid rasterizer
`timescale 1ns / 100ps

module oriented_box_grid_rasterizer_top_test;
  import obrast_pkg::*;

  localparam longint FOOT_DIAG = 10264;
  localparam longint FOOT_HALF_LEN = 64'sd21110623253299;
  localparam longint FOOT_HALF_WID = 64'sd6333186975989;
  localparam longint OFF_CLAMP = 64'sd33554432;
  localparam int     CYCLE_LIMIT = 2000000;
  localparam logic   OP_CAR = 1'b0;
  localparam logic   OP_OBSTACLE = 1'b1;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // shadow of the configuration registers
  longint grid_ox, grid_oy, grid_cell, grid_cpm;
  longint win_x0, win_y0, win_x1, win_y1;

  out_item_t lethal_cells_q[$];
  int sender_idle_pct;
  int receiver_idle_pct;
  int errors;
  int cycles;

  oriented_box_grid_rasterizer_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // floor of v / 2^32
  function automatic longint fl32(longint v);
    return v >>> 32;
  endfunction

  function automatic longint cl32(longint v);
    return -((-v) >>> 32);
  endfunction

  function automatic longint clamp_off(longint v);
    if (v > OFF_CLAMP) return OFF_CLAMP;
    if (v < -OFF_CLAMP) return -OFF_CLAMP;
    return v;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void push_cell(longint gx, longint gy, logic last);
    out_item_t c;
    c.cell_x = gx[9:0];
    c.cell_y = gy[9:0];
    c.last_cell = last;
    lethal_cells_q.push_back(c);
  endfunction

  // predicts the lethal cells one request marks
  function automatic void predict_lethal_cells(in_item_t r);
    longint px, py, qz, qw, cq, sq, x0, x1, y0, y1, gx, gy, dx, dy, lx, ly;
    longint hx[$], hy[$];
    px = r.pos_x;
    py = r.pos_y;
    qz = r.quat_z;
    qw = r.quat_w;
    if (r.operation == OP_OBSTACLE) begin
      dx = px - grid_ox;
      dy = py - grid_oy;
      if (dx < 0 || dy < 0) return;
      x0 = fl32(dx * grid_cpm);
      y0 = fl32(dy * grid_cpm);
      if (x0 >= 1024 || y0 >= 1024) return;
      push_cell(x0, y0, 1'b1);
      return;
    end
    cq = qw * qw - qz * qz;
    sq = 2 * qz * qw;
    x0 = fl32((px - FOOT_DIAG - grid_ox) * grid_cpm);
    x1 = cl32((px + FOOT_DIAG - grid_ox) * grid_cpm);
    y0 = fl32((py - FOOT_DIAG - grid_oy) * grid_cpm);
    y1 = cl32((py + FOOT_DIAG - grid_oy) * grid_cpm);
    if (x0 < win_x0) x0 = win_x0;
    if (x1 > win_x1 - 1) x1 = win_x1 - 1;
    if (y0 < win_y0) y0 = win_y0;
    if (y1 > win_y1 - 1) y1 = win_y1 - 1;
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > 1023) x1 = 1023;
    if (y1 > 1023) y1 = 1023;
    for (gx = x0; gx <= x1; gx++) begin
      for (gy = y0; gy <= y1; gy++) begin
        dx = clamp_off(2 * grid_ox + (2 * gx + 1) * grid_cell - 2 * px);
        dy = clamp_off(2 * grid_oy + (2 * gy + 1) * grid_cell - 2 * py);
        lx = dx * cq + dy * sq;
        ly = dy * cq - dx * sq;
        if (mag(lx) <= FOOT_HALF_LEN && mag(ly) <= FOOT_HALF_WID && hx.size() < 64) begin
          hx.push_back(gx);
          hy.push_back(gy);
        end
      end
    end
    foreach (hx[i]) push_cell(hx[i], hy[i], i == hx.size() - 1);
  endfunction

  // receiver stall and result check
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (lethal_cells_q.size() == 0) begin
          $display("%0t unexpected cell x=%0d y=%0d last=%0d", $time,
                   out_data.cell_x, out_data.cell_y, out_data.last_cell);
          errors++;
        end else begin
          want = lethal_cells_q.pop_front();
          if (want.cell_x !== out_data.cell_x) begin
            $display("%0t cell_x expected %0d actual %0d", $time, want.cell_x, out_data.cell_x);
            errors++;
          end
          if (want.cell_y !== out_data.cell_y) begin
            $display("%0t cell_y expected %0d actual %0d", $time, want.cell_y, out_data.cell_y);
            errors++;
          end
          if (want.last_cell !== out_data.last_cell) begin
            $display("%0t last_cell expected %0d actual %0d", $time,
                     want.last_cell, out_data.last_cell);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  // sends one request and predicts its cells when it is taken
  task automatic send_request(in_item_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_lethal_cells(r);
  endtask

  // drop the request line and let every job drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (lethal_cells_q.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ORIGIN_X:  grid_ox = longint'($signed(val));
      CFG_ORIGIN_Y:  grid_oy = longint'($signed(val));
      CFG_CELL_SIZE: grid_cell = val[16:0];
      CFG_CELLS_PM:  grid_cpm = val[20:0];
      CFG_WIN_MIN_X: win_x0 = val[10:0];
      CFG_WIN_MIN_Y: win_y0 = val[10:0];
      CFG_WIN_MAX_X: win_x1 = val[10:0];
      default:       win_y1 = val[10:0];
    endcase
  endtask

  // grid setup: origin, cell size, cells per metre, window
  task automatic setup_grid(longint ox, longint oy, longint cs, longint cpm,
                            int wx0, int wy0, int wx1, int wy1);
    wait_idle();
    write_reg(CFG_ORIGIN_X, ox[31:0]);
    write_reg(CFG_ORIGIN_Y, oy[31:0]);
    write_reg(CFG_CELL_SIZE, cs[31:0]);
    write_reg(CFG_CELLS_PM, cpm[31:0]);
    write_reg(CFG_WIN_MIN_X, wx0);
    write_reg(CFG_WIN_MIN_Y, wy0);
    write_reg(CFG_WIN_MAX_X, wx1);
    write_reg(CFG_WIN_MAX_Y, wy1);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t make_req(logic op, longint x, longint y, int qz, int qw);
    in_item_t r;
    r.operation = op;
    r.pos_x = x[31:0];
    r.pos_y = y[31:0];
    r.quat_z = qz[15:0];
    r.quat_w = qw[15:0];
    return r;
  endfunction

  // random unit-ish heading in Q1.15
  function automatic in_item_t rand_car(longint lo, longint hi);
    real a;
    a = $urandom_range(6283) / 2000.0;
    return make_req(OP_CAR, lo + $urandom_range(hi - lo), lo + $urandom_range(hi - lo),
                    $rtoi($sin(a) * 32767.0), $rtoi($cos(a) * 32767.0));
  endfunction

  // extremes of fields, both operations and the corner cases
  task automatic test_directed();
    send_request(make_req(OP_CAR, 65536, 65536, 0, 32767));
    send_request(make_req(OP_CAR, 65536, 65536, 23170, 23170));
    send_request(make_req(OP_CAR, 65536, 65536, 32767, 0));
    send_request(make_req(OP_CAR, 65536, 65536, -32768, -32768));
    send_request(make_req(OP_CAR, 65536, 65536, 0, 0));
    send_request(make_req(OP_CAR, 0, 0, -23170, 23170));
    send_request(make_req(OP_CAR, -2147483648, -2147483648, 0, 32767));
    send_request(make_req(OP_CAR, 2147483647, 2147483647, 32767, -32768));
    send_request(make_req(OP_CAR, 3355000, 3355000, 0, 32767));
    send_request(make_req(OP_OBSTACLE, 0, 0, 0, 0));
    send_request(make_req(OP_OBSTACLE, -1, 100, 0, 0));
    send_request(make_req(OP_OBSTACLE, 100, -1, -1, -1));
    send_request(make_req(OP_OBSTACLE, 3355000, 3355000, 0, 0));
    send_request(make_req(OP_OBSTACLE, 3360000, 20000, 0, 0));
    send_request(make_req(OP_OBSTACLE, 2147483647, -2147483648, 0, 0));
    // window empty, then window cutting the footprint
    setup_grid(0, 0, 3277, 1310720, 5, 5, 5, 5);
    send_request(make_req(OP_CAR, 65536, 65536, 0, 32767));
    send_request(make_req(OP_OBSTACLE, 65536, 65536, 0, 0));
    setup_grid(0, 0, 3277, 1310720, 20, 20, 22, 1024);
    send_request(make_req(OP_CAR, 65536, 65536, 0, 32767));
    // mismatched cell size and reciprocal with far offsets and big quaternion
    setup_grid(-2147483648, 2147483647, 65536, 1638400, 0, 0, 1024, 1024);
    send_request(make_req(OP_CAR, -2147483648, 2147483647, 32767, 32767));
    setup_grid(0, 0, 2621, 65536, 0, 0, 1024, 1024);
    send_request(make_req(OP_CAR, 655360, 655360, -32768, 32767));
  endtask

  // random requests: mostly cars in the grid, some obstacles and noise
  task automatic test_random(int count);
    int k;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(9))
        0: send_request(make_req(1'($urandom_range(1)), longint'($signed($urandom())),
                                 longint'($signed($urandom())), $urandom(), $urandom()));
        1, 2: send_request(make_req(OP_OBSTACLE, $urandom_range(3500000),
                                    $urandom_range(3500000), $urandom(), $urandom()));
        default: send_request(rand_car(0, 3400000));
      endcase
    end
  endtask

  // random grids with a matching reciprocal and random window
  task automatic test_settings();
    longint cs, ox, oy;
    int p, w0, w1;
    for (p = 0; p < 3; p++) begin
      cs = $urandom_range(65536, 2621);
      ox = longint'($signed($urandom_range(2000000))) - 1000000;
      oy = longint'($signed($urandom_range(2000000))) - 1000000;
      w0 = $urandom_range(3);
      w1 = $urandom_range(1024, 1020);
      setup_grid(ox, oy, cs, (64'd1 << 32) / cs, w0, w0, w1, w1);
      test_random(20);
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    sender_idle_pct = 25;
    receiver_idle_pct = 81;
    grid_ox = 0; grid_oy = 0; grid_cell = 3277; grid_cpm = 1310720;
    win_x0 = 0; win_y0 = 0; win_x1 = 1024; win_y1 = 1024;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    setup_grid(0, 0, 3277, 1310720, 0, 0, 1024, 1024);
    test_random(60);
    sender_idle_pct = 81;
    receiver_idle_pct = 25;
    test_settings();
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    setup_grid(0, 0, 3277, 1310720, 0, 0, 1024, 1024);
    test_random(70);
    wait_idle();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: oriented_box_grid_rasterizer_top.f
+incdir+rtl
rtl/obrast_pkg.sv
rtl/obrast_queue.sv
rtl/obrast_front.sv
rtl/obrast_back.sv
rtl/oriented_box_grid_rasterizer_top.sv
dv/oriented_box_grid_rasterizer_top_test.sv
